>>> hw/rtl/tssu_pkg.sv
// tssu_pkg: shared types, codes and sizes of the scanline sample unpacker
// depends on nothing; the front, queue, back and core refer to it by scoped names

package tssu_pkg;

  // palette store
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int unsigned PAL_W       = 24;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // floor(x / 257) for 16-bit x equals (x * 65281) >> 24
  localparam logic [16:0] SCALE_MUL = 17'd65281;

  // samples-per-pixel values that bring an alpha sample
  localparam logic [2:0] SPP_ALPHA_GRAY = 3'd2;
  localparam logic [2:0] SPP_ALPHA_RGB  = 3'd4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_BITS  = 2'd1,
    CFG_SPP   = 2'd2,
    CFG_WIDTH = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_MIN_BLACK = 2'd0,
    MODE_MIN_WHITE = 2'd1,
    MODE_PALETTE   = 2'd2,
    MODE_RGB       = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BITS_1 = 2'd0,
    BITS_2 = 2'd1,
    BITS_4 = 2'd2,
    BITS_8 = 2'd3
  } bits_e;

  typedef struct packed {
    mode_e       mode;
    bits_e       bits_code;
    logic [2:0]  spp;
    logic [15:0] row_width;
  } cfg_t;

  // addr holds the scanline byte for data items, the entry index for palette writes
  typedef struct packed {
    logic             is_pal;
    logic [7:0]       addr;
    logic [PAL_W-1:0] rgb;
  } q_item_t;

endpackage

>>> hw/rtl/tssu_ram.sv
// tssu_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module tssu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tssu_front.sv
// tssu_front: input side, classifies items and scales palette components to 8 bits
// depends on tssu_pkg

module tssu_front (
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [63:0]       s_data_i,
  input  logic              s_kind_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output tssu_pkg::q_item_t q_item_o
);

  logic [32:0] prod_r;
  logic [32:0] prod_g;
  logic [32:0] prod_b;

  // reciprocal multiply, exact for every 16-bit value
  assign prod_r = 33'(s_data_i[31:16]) * 33'(tssu_pkg::SCALE_MUL);
  assign prod_g = 33'(s_data_i[47:32]) * 33'(tssu_pkg::SCALE_MUL);
  assign prod_b = 33'(s_data_i[63:48]) * 33'(tssu_pkg::SCALE_MUL);

  assign s_ready_o = q_ready_i;
  assign q_push_o  = s_valid_i && q_ready_i;

  always_comb begin
    q_item_o.is_pal = s_kind_i;
    q_item_o.addr   = s_kind_i ? s_data_i[15:8] : s_data_i[7:0];
    q_item_o.rgb    = {prod_r[31:24], prod_g[31:24], prod_b[31:24]};
  end

endmodule

>>> hw/rtl/tssu_queue.sv
// tssu_queue: short flop queue that decouples the front from the back
// depends on tssu_pkg

module tssu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tssu_pkg::q_item_t item_i,
  output logic              ready_o,
  output logic              valid_o,
  output tssu_pkg::q_item_t item_o,
  input  logic              pop_i
);

  tssu_pkg::q_item_t         slot_q [tssu_pkg::QDEPTH];
  logic [tssu_pkg::QAW-1:0]  wptr_q, wptr_d;
  logic [tssu_pkg::QAW-1:0]  rptr_q, rptr_d;
  logic [tssu_pkg::QAW:0]    count_q, count_d;

  assign ready_o = count_q != (tssu_pkg::QAW+1)'(tssu_pkg::QDEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

>>> hw/rtl/tssu_back.sv
// tssu_back: sample sequencer, palette store and output stage
// depends on tssu_pkg and tssu_ram

module tssu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tssu_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  tssu_pkg::q_item_t q_item_i,
  output logic              q_pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [47:0]       m_data_o,
  output logic              m_row_end_o,
  output logic              m_last_o
);

  logic [2:0]  samp_idx_q, samp_idx_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  held1_q, held1_d;
  logic [7:0]  held2_q, held2_d;
  logic [7:0]  held3_q, held3_d;
  logic [15:0] col_q, col_d;
  logic        s2_valid_q, s2_valid_d;

  logic        s2_pal_q;
  logic [7:0]  s2_red_q;
  logic [7:0]  s2_green_q;
  logic [7:0]  s2_blue_q;
  logic [7:0]  s2_alpha_q;
  logic [15:0] s2_col_q;
  logic        s2_row_end_q;
  logic        s2_last_q;

  logic        adv;
  logic        fire;
  logic        ram_we;
  logic        s2_load;
  logic [2:0]  shamt;
  logic [7:0]  shifted;
  logic [7:0]  smp;
  logic [7:0]  mask;
  logic [2:0]  last_idx;
  logic [2:0]  needed;
  logic        hold;
  logic [7:0]  v0, v1, v2, v3;
  logic        end_row;
  logic [2:0]  remaining;
  logic        last_flag;
  logic        byte_done;
  logic [7:0]  red_c, green_c, blue_c, alpha_c;
  logic [tssu_pkg::PAL_W-1:0] rdata;

  // the sequencer moves only when the output stage can take a pixel
  assign adv    = !s2_valid_q || m_ready_i;
  assign fire   = q_valid_i && adv;
  assign ram_we = fire && q_item_i.is_pal;

  always_comb begin
    case (cfg_i.bits_code)
      tssu_pkg::BITS_1: begin
        mask     = 8'h01;
        last_idx = 3'd7;
        shamt    = samp_idx_q;
      end
      tssu_pkg::BITS_2: begin
        mask     = 8'h03;
        last_idx = 3'd3;
        shamt    = {samp_idx_q[1:0], 1'b0};
      end
      tssu_pkg::BITS_4: begin
        mask     = 8'h0f;
        last_idx = 3'd1;
        shamt    = {samp_idx_q[0], 2'b00};
      end
      default: begin
        mask     = 8'hff;
        last_idx = 3'd0;
        shamt    = 3'd0;
      end
    endcase
  end

  assign shifted = q_item_i.addr << shamt;

  always_comb begin
    case (cfg_i.bits_code)
      tssu_pkg::BITS_1: smp = {7'd0, shifted[7]};
      tssu_pkg::BITS_2: smp = {6'd0, shifted[7:6]};
      tssu_pkg::BITS_4: smp = {4'd0, shifted[7:4]};
      default:          smp = shifted;
    endcase
  end

  always_comb begin
    if (cfg_i.mode == tssu_pkg::MODE_RGB) begin
      needed = (cfg_i.spp == tssu_pkg::SPP_ALPHA_RGB) ? 3'd4 : 3'd3;
    end else begin
      needed = (cfg_i.spp == tssu_pkg::SPP_ALPHA_GRAY) ? 3'd2 : 3'd1;
    end
  end

  assign hold = ({1'b0, phase_q} + 3'd1) < needed;

  // the sample just cut lands at the current phase, earlier ones come from the holds
  assign v0 = (phase_q == 2'd0) ? smp : held1_q;
  assign v1 = (phase_q == 2'd1) ? smp : held2_q;
  assign v2 = (phase_q == 2'd2) ? smp : held3_q;
  assign v3 = (phase_q == 2'd3) ? smp : 8'd0;

  assign end_row   = ({1'b0, col_q} + 17'd1) >= {1'b0, cfg_i.row_width};
  // another pixel from this byte needs a full set of samples after this one
  assign remaining = last_idx - samp_idx_q;
  assign last_flag = end_row || (remaining < needed);
  assign byte_done = (samp_idx_q == last_idx) || (!hold && end_row);

  assign s2_load = fire && !q_item_i.is_pal && !hold;
  assign q_pop_o = fire && (q_item_i.is_pal || byte_done);

  always_comb begin
    red_c   = 8'd0;
    green_c = 8'd0;
    blue_c  = 8'd0;
    case (cfg_i.mode)
      tssu_pkg::MODE_MIN_BLACK: blue_c = v0;
      tssu_pkg::MODE_MIN_WHITE: blue_c = mask & ~v0;
      tssu_pkg::MODE_RGB: begin
        red_c   = v0;
        green_c = v1;
        blue_c  = v2;
      end
      default: ;
    endcase
    if (cfg_i.mode == tssu_pkg::MODE_RGB) begin
      alpha_c = (needed == 3'd4) ? v3 : 8'd0;
    end else begin
      alpha_c = (needed == 3'd2) ? v1 : 8'd0;
    end
  end

  always_comb begin
    samp_idx_d = samp_idx_q;
    phase_d    = phase_q;
    held1_d    = held1_q;
    held2_d    = held2_q;
    held3_d    = held3_q;
    col_d      = col_q;
    s2_valid_d = s2_valid_q;
    if (adv) begin
      s2_valid_d = s2_load;
    end
    if (fire && !q_item_i.is_pal) begin
      samp_idx_d = byte_done ? 3'd0 : samp_idx_q + 3'd1;
      if (hold) begin
        case (phase_q)
          2'd0:    held1_d = smp;
          2'd1:    held2_d = smp;
          default: held3_d = smp;
        endcase
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = 2'd0;
        col_d   = end_row ? 16'd0 : col_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_idx_q <= '0;
      phase_q    <= '0;
      held1_q    <= '0;
      held2_q    <= '0;
      held3_q    <= '0;
      col_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      samp_idx_q <= samp_idx_d;
      phase_q    <= phase_d;
      held1_q    <= held1_d;
      held2_q    <= held2_d;
      held3_q    <= held3_d;
      col_q      <= col_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_pal_q     <= cfg_i.mode == tssu_pkg::MODE_PALETTE;
      s2_red_q     <= red_c;
      s2_green_q   <= green_c;
      s2_blue_q    <= blue_c;
      s2_alpha_q   <= alpha_c;
      s2_col_q     <= col_q;
      s2_row_end_q <= end_row;
      s2_last_q    <= last_flag;
    end
  end

  // palette lookup runs alongside the output stage load
  tssu_ram #(
    .WIDTH (tssu_pkg::PAL_W),
    .DEPTH (tssu_pkg::PAL_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_item_i.addr),
    .wdata_i (q_item_i.rgb),
    .re_i    (adv),
    .raddr_i (v0),
    .rdata_o (rdata)
  );

  assign m_valid_o   = s2_valid_q;
  assign m_row_end_o = s2_row_end_q;
  assign m_last_o    = s2_last_q;
  assign m_data_o    = {s2_col_q,
                        s2_alpha_q,
                        s2_pal_q ? rdata[7:0]   : s2_blue_q,
                        s2_pal_q ? rdata[15:8]  : s2_green_q,
                        s2_pal_q ? rdata[23:16] : s2_red_q};

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("queue popped while empty");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load && end_row |=> col_q == 16'd0)
    else $error("column not cleared after row end");

  a_row_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && s2_row_end_q |-> s2_last_q)
    else $error("row end pixel not marked last of its byte");

  a_stall_freezes_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && !m_ready_i |=> $stable(samp_idx_q) && $stable(col_q) && $stable(phase_q))
    else $error("sequencer moved while output stalled");

endmodule

>>> hw/rtl/tiff_scanline_sample_unpacker_core.sv
// tiff_scanline_sample_unpacker_core: top level, configuration registers and
// the front, queue and back of the unpacker; depends on tssu_pkg, tssu_front, tssu_queue, tssu_back
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: byte, index, r, g, b; tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: r, g, b, a, column; tuser: row end
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// a data byte is cut at one sample per cycle while the output does not stall:
// one sample at 8 bits, up to 8 at 1 bit, fewer when a row ends inside it; the sample
// sequencer in the back does this, pops palette writes, and registers each pixel
// reset clears the sequencer and queue; palette entries are undefined until written
// an output stall freezes the sequencer while the 4-entry queue keeps taking items

module tiff_scanline_sample_unpacker_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // data_byte[7:0], palette_index[15:8], palette_red[31:16],
  // palette_green[47:32], palette_blue[63:48]
  input  logic [63:0]                      s_axis_tdata,
  // kind[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], pixel_column[47:32]
  output logic [47:0]                      m_axis_tdata,
  // row_end[0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [tssu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tssu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  tssu_pkg::cfg_t    cfg_q, cfg_d;
  logic              q_ready;
  logic              q_push;
  logic              q_valid;
  logic              q_pop;
  tssu_pkg::q_item_t push_item;
  tssu_pkg::q_item_t head_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tssu_pkg::cfg_idx_e'(cfg_idx_i))
        tssu_pkg::CFG_MODE:  cfg_d.mode      = tssu_pkg::mode_e'(cfg_data_i[1:0]);
        tssu_pkg::CFG_BITS:  cfg_d.bits_code = tssu_pkg::bits_e'(cfg_data_i[1:0]);
        tssu_pkg::CFG_SPP:   cfg_d.spp       = cfg_data_i[2:0];
        tssu_pkg::CFG_WIDTH: cfg_d.row_width = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= tssu_pkg::MODE_MIN_BLACK;
      cfg_q.bits_code <= tssu_pkg::BITS_8;
      cfg_q.spp       <= 3'd1;
      cfg_q.row_width <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tssu_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_kind_i  (s_axis_tuser),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_item_o  (push_item)
  );

  tssu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (q_pop)
  );

  tssu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_row_end_o (m_axis_tuser),
    .m_last_o    (m_axis_tlast)
  );

endmodule
